/* hdl/two_way_set_assoc_cache_lookup_core_defines.svh */
// assertion macros for the cache lookup core
`ifndef TWO_WAY_SET_ASSOC_CACHE_LOOKUP_CORE_DEFINES_SVH
`define TWO_WAY_SET_ASSOC_CACHE_LOOKUP_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLKRST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLKRST(lbl, clk, rstn, prop)
`define ASSERT_CLK(lbl, clk, prop)
`endif

`endif

/* hdl/tsacl_pkg.sv */
`default_nettype none

package tsacl_pkg;

    localparam int ADDR_W    = 16;
    localparam int LINE_W    = 32;
    localparam int TAG_W     = 8;
    localparam int TAG_LSB   = 8;
    localparam int SET_LSB   = 2;
    localparam int IDX_W     = ADDR_W - SET_LSB;
    localparam int SET_OUT_W = 6;
    localparam int CNT_OUT_W = 16;

    localparam logic [1:0] EV_HIT_W0  = 2'd0;
    localparam logic [1:0] EV_HIT_W1  = 2'd1;
    localparam logic [1:0] EV_FILL_W0 = 2'd2;
    localparam logic [1:0] EV_FILL_W1 = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [LINE_W-1:0] line;
    } way_entry_t;

    typedef struct packed {
        logic       victim_w1;
        way_entry_t w1;
        way_entry_t w0;
    } set_entry_t;

endpackage

`default_nettype wire

/* hdl/tsacl_ram.sv */
`default_nettype none

module tsacl_ram #(
    parameter int WIDTH = 83,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/two_way_set_assoc_cache_lookup_core.sv */
`default_nettype none
`include "two_way_set_assoc_cache_lookup_core_defines.svh"

// Two-way set-associative cache lookup with per-set LRU replacement and
// saturating per-way hit and fill counters. Each access passes through the
// transfer (reciprocal multiply for the set number), ST_INDEX to finish the
// set reduction and read the set memory, and ST_LOOKUP to compare tags,
// write the set back and load the result register. All ways of a set live
// in one word of a single synchronous RAM with one read and one write port;
// accesses never overlap, so no forwarding is needed. A result waiting in
// the output register holds off the write-back of the next access but not
// its transfer. After reset a clearing pass over all NUM_SETS sets
// invalidates every set and marks way 1 as victim; s_ready stays low
// during it.
module two_way_set_assoc_cache_lookup_core #(
    parameter int NUM_SETS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_address,
    input  wire logic [31:0] s_fill_line,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic             m_way,
    output logic [5:0]       m_set_index,
    output logic [7:0]       m_tag_value,
    output logic [31:0]      m_line_data,
    output logic [15:0]      m_hits_way0,
    output logic [15:0]      m_hits_way1,
    output logic [15:0]      m_misses_way0,
    output logic [15:0]      m_misses_way1
);

    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int SHIFT   = tsacl_pkg::IDX_W + SET_W;
    localparam int RECIP   = ((1 << SHIFT) + NUM_SETS - 1) / NUM_SETS;
    localparam int PROD_W  = tsacl_pkg::IDX_W + 16;
    localparam int QN_W    = tsacl_pkg::IDX_W + SET_W + 1;
    localparam int ENTRY_W = $bits(tsacl_pkg::set_entry_t);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    tsacl_pkg::state_t state_reg, state_next;

    logic [SET_W-1:0]            clr_idx_reg, clr_idx_next;
    logic [tsacl_pkg::ADDR_W-1:0] addr_reg;
    logic [31:0]                 fill_reg;
    logic [tsacl_pkg::IDX_W-1:0] quot_reg;
    logic [SET_W-1:0]            set_reg;

    logic [tsacl_pkg::IDX_W-1:0] s_idx;
    logic [PROD_W-1:0]           prod;
    logic [tsacl_pkg::IDX_W-1:0] quot_next;
    logic [QN_W-1:0]             qn;
    logic [QN_W-1:0]             rem;
    logic [SET_W-1:0]            set_calc;
    logic [tsacl_pkg::TAG_W-1:0] tag;

    logic                        ram_we;
    logic [SET_W-1:0]            ram_waddr;
    logic [SET_W-1:0]            ram_raddr;
    tsacl_pkg::set_entry_t       ram_wdata;
    tsacl_pkg::set_entry_t       ram_rdata;
    tsacl_pkg::set_entry_t       upd_entry;
    tsacl_pkg::set_entry_t       clr_entry;
    logic [ENTRY_W-1:0]          ram_rdata_raw;

    logic hit0;
    logic hit1;
    logic res_hit;
    logic res_way;
    logic [31:0] res_line;
    logic [1:0]  res_event;
    logic        out_load;

    logic [COUNT_BITS-1:0] cnt_reg [4];
    logic [COUNT_BITS-1:0] cnt_next [4];

    logic                  m_valid_reg, m_valid_next;
    logic                  m_hit_reg;
    logic                  m_way_reg;
    logic [5:0]            m_set_index_reg;
    logic [7:0]            m_tag_value_reg;
    logic [31:0]           m_line_data_reg;
    logic [15:0]           m_cnt_reg [4];
    logic [SET_W+5:0]      set_ext;
    logic [COUNT_BITS+15:0] cnt_ext [4];

    // set number = (address >> 2) mod NUM_SETS via exact reciprocal
    assign s_idx     = s_address[tsacl_pkg::ADDR_W-1:tsacl_pkg::SET_LSB];
    assign prod      = PROD_W'(s_idx) * PROD_W'(RECIP);
    assign quot_next = tsacl_pkg::IDX_W'(prod >> SHIFT);
    assign qn        = QN_W'(quot_reg) * QN_W'(NUM_SETS);
    assign rem       = QN_W'(addr_reg[tsacl_pkg::ADDR_W-1:tsacl_pkg::SET_LSB]) - qn;
    assign set_calc  = rem[SET_W-1:0];
    assign tag       = addr_reg[tsacl_pkg::ADDR_W-1:tsacl_pkg::TAG_LSB];

    tsacl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SETS)
    ) u_set_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata_raw)
    );

    assign ram_rdata = tsacl_pkg::set_entry_t'(ram_rdata_raw);

    // tag compare, way 0 first
    always_comb begin
        hit0     = ram_rdata.w0.valid && (ram_rdata.w0.tag == tag);
        hit1     = !hit0 && ram_rdata.w1.valid && (ram_rdata.w1.tag == tag);
        res_hit  = hit0 || hit1;
        res_way  = hit0 ? 1'b0 : (hit1 ? 1'b1 : ram_rdata.victim_w1);
        res_line = hit0 ? ram_rdata.w0.line : (hit1 ? ram_rdata.w1.line : fill_reg);
        res_event = res_hit ? {1'b0, res_way} : {1'b1, res_way};

        upd_entry           = ram_rdata;
        upd_entry.victim_w1 = !res_way;
        if (!res_hit) begin
            if (res_way) begin
                upd_entry.w1.valid = 1'b1;
                upd_entry.w1.tag   = tag;
                upd_entry.w1.line  = fill_reg;
            end else begin
                upd_entry.w0.valid = 1'b1;
                upd_entry.w0.tag   = tag;
                upd_entry.w0.line  = fill_reg;
            end
        end

        clr_entry           = '0;
        clr_entry.victim_w1 = 1'b1;
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        case (state_reg)
            tsacl_pkg::ST_CLEAR: begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == SET_W'(NUM_SETS - 1)) begin
                    state_next = tsacl_pkg::ST_IDLE;
                end
            end
            tsacl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = tsacl_pkg::ST_INDEX;
                end
            end
            tsacl_pkg::ST_INDEX: begin
                state_next = tsacl_pkg::ST_LOOKUP;
            end
            tsacl_pkg::ST_LOOKUP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = tsacl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tsacl_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs of the state machine
    always_comb begin
        s_ready   = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_raddr = set_reg;
        ram_wdata = upd_entry;
        case (state_reg)
            tsacl_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = clr_entry;
            end
            tsacl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            tsacl_pkg::ST_INDEX: begin
                ram_raddr = set_calc;
            end
            tsacl_pkg::ST_LOOKUP: begin
                out_load = !m_valid_reg || m_ready;
                ram_we   = out_load;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // saturating event counters
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            cnt_next[i] = cnt_reg[i];
        end
        if (out_load && (cnt_reg[res_event] != CNT_MAX)) begin
            cnt_next[res_event] = cnt_reg[res_event] + 1'b1;
        end
        for (int i = 0; i < 4; i++) begin
            cnt_ext[i] = {16'b0, cnt_next[i]};
        end
        set_ext = {6'b0, set_reg};
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tsacl_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < 4; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            addr_reg <= s_address;
            fill_reg <= s_fill_line;
            quot_reg <= quot_next;
        end
        if (state_reg == tsacl_pkg::ST_INDEX) begin
            set_reg <= set_calc;
        end
        if (out_load) begin
            m_hit_reg       <= res_hit;
            m_way_reg       <= res_way;
            m_set_index_reg <= set_ext[5:0];
            m_tag_value_reg <= tag;
            m_line_data_reg <= res_line;
            for (int i = 0; i < 4; i++) begin
                m_cnt_reg[i] <= cnt_ext[i][15:0];
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_hit         = m_hit_reg;
    assign m_way         = m_way_reg;
    assign m_set_index   = m_set_index_reg;
    assign m_tag_value   = m_tag_value_reg;
    assign m_line_data   = m_line_data_reg;
    assign m_hits_way0   = m_cnt_reg[tsacl_pkg::EV_HIT_W0];
    assign m_hits_way1   = m_cnt_reg[tsacl_pkg::EV_HIT_W1];
    assign m_misses_way0 = m_cnt_reg[tsacl_pkg::EV_FILL_W0];
    assign m_misses_way1 = m_cnt_reg[tsacl_pkg::EV_FILL_W1];

    // a write-back never leaves the same tag valid in both ways
    `ASSERT_CLKRST(a_no_dup_tag, aclk, aresetn, (ram_we && (state_reg == tsacl_pkg::ST_LOOKUP)) |-> !(ram_wdata.w0.valid && ram_wdata.w1.valid && (ram_wdata.w0.tag == ram_wdata.w1.tag)))
    // the way just used never stays the victim
    `ASSERT_CLKRST(a_lru_flip, aclk, aresetn, out_load |-> (ram_wdata.victim_w1 != res_way))
    // a pending result is never overwritten
    `ASSERT_CLKRST(a_no_overwrite, aclk, aresetn, out_load |-> (!m_valid_reg || m_ready))
    // m_valid never rises out of reset or the clearing pass
    `ASSERT_CLK(a_clear_blocks, aclk, (!aresetn || (state_reg == tsacl_pkg::ST_CLEAR)) |=> !(m_valid_reg && $rose(m_valid_reg)) || $past(state_reg == tsacl_pkg::ST_LOOKUP))

endmodule

`default_nettype wire

/* tb/tb_two_way_set_assoc_cache_lookup_core.sv */
module tb_two_way_set_assoc_cache_lookup_core;

    localparam int NUM_SETS    = 64;
    localparam int COUNT_BITS  = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [tsacl_pkg::ADDR_W-1:0] address;
        logic [tsacl_pkg::LINE_W-1:0] fill_line;
    } access_t;

    typedef struct packed {
        logic                            hit;
        logic                            way;
        logic [tsacl_pkg::SET_OUT_W-1:0] set_index;
        logic [tsacl_pkg::TAG_W-1:0]     tag_value;
        logic [tsacl_pkg::LINE_W-1:0]    line_data;
        logic [tsacl_pkg::CNT_OUT_W-1:0] hits_way0;
        logic [tsacl_pkg::CNT_OUT_W-1:0] hits_way1;
        logic [tsacl_pkg::CNT_OUT_W-1:0] misses_way0;
        logic [tsacl_pkg::CNT_OUT_W-1:0] misses_way1;
    } lookup_result_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [tsacl_pkg::ADDR_W-1:0] s_address = '0;
    logic [tsacl_pkg::LINE_W-1:0] s_fill_line = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_hit;
    logic                         m_way;
    logic [5:0]                   m_set_index;
    logic [7:0]                   m_tag_value;
    logic [31:0]                  m_line_data;
    logic [15:0]                  m_hits_way0;
    logic [15:0]                  m_hits_way1;
    logic [15:0]                  m_misses_way0;
    logic [15:0]                  m_misses_way1;

    // cache contents as the block should hold them
    logic                         way_valid [2][NUM_SETS];
    logic [tsacl_pkg::TAG_W-1:0]  way_tag   [2][NUM_SETS];
    logic [tsacl_pkg::LINE_W-1:0] way_line  [2][NUM_SETS];
    logic                         victim_w1 [NUM_SETS];
    logic [COUNT_BITS-1:0]        event_cnt [4];

    access_t        pending_q[$];
    lookup_result_t expected_q[$];

    logic           s_taken = 1'b0;
    int             src_idle_pct = 0;
    int             sink_stall_pct = 0;
    logic           hold_arm = 1'b0;
    logic           hold_done = 1'b0;
    int             hold_left = 0;
    int             items_queued = 0;
    int             results_done = 0;
    int             mismatches = 0;
    int             cycle_cnt = 0;

    two_way_set_assoc_cache_lookup_core #(
        .NUM_SETS   (NUM_SETS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_address     (s_address),
        .s_fill_line   (s_fill_line),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_way         (m_way),
        .m_set_index   (m_set_index),
        .m_tag_value   (m_tag_value),
        .m_line_data   (m_line_data),
        .m_hits_way0   (m_hits_way0),
        .m_hits_way1   (m_hits_way1),
        .m_misses_way0 (m_misses_way0),
        .m_misses_way1 (m_misses_way1)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void clear_cache_state();
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < 2; w++) begin
                way_valid[w][s] = 1'b0;
                way_tag[w][s]   = '0;
                way_line[w][s]  = '0;
            end
            victim_w1[s] = 1'b1;
        end
        for (int k = 0; k < 4; k++)
            event_cnt[k] = '0;
    endfunction

    function automatic lookup_result_t cache_access(input access_t acc);
        int unsigned                 set_no;
        logic [tsacl_pkg::TAG_W-1:0] tag;
        logic [1:0]                  ev;
        lookup_result_t              r;
        set_no = (acc.address >> tsacl_pkg::SET_LSB) % NUM_SETS;
        tag    = acc.address[tsacl_pkg::TAG_LSB +: tsacl_pkg::TAG_W];
        r.hit  = 1'b1;
        if (way_valid[0][set_no] && way_tag[0][set_no] == tag) begin
            r.way = 1'b0;
            r.line_data = way_line[0][set_no];
            victim_w1[set_no] = 1'b1;
            ev = tsacl_pkg::EV_HIT_W0;
        end else if (way_valid[1][set_no] && way_tag[1][set_no] == tag) begin
            r.way = 1'b1;
            r.line_data = way_line[1][set_no];
            victim_w1[set_no] = 1'b0;
            ev = tsacl_pkg::EV_HIT_W1;
        end else begin
            r.hit = 1'b0;
            r.way = victim_w1[set_no];
            r.line_data = acc.fill_line;
            way_valid[r.way][set_no] = 1'b1;
            way_tag[r.way][set_no]   = tag;
            way_line[r.way][set_no]  = acc.fill_line;
            victim_w1[set_no] = ~r.way;
            ev = r.way ? tsacl_pkg::EV_FILL_W1 : tsacl_pkg::EV_FILL_W0;
        end
        if (event_cnt[ev] != {COUNT_BITS{1'b1}})
            event_cnt[ev] = event_cnt[ev] + 1'b1;
        r.set_index   = set_no[tsacl_pkg::SET_OUT_W-1:0];
        r.tag_value   = tag;
        r.hits_way0   = event_cnt[tsacl_pkg::EV_HIT_W0][tsacl_pkg::CNT_OUT_W-1:0];
        r.hits_way1   = event_cnt[tsacl_pkg::EV_HIT_W1][tsacl_pkg::CNT_OUT_W-1:0];
        r.misses_way0 = event_cnt[tsacl_pkg::EV_FILL_W0][tsacl_pkg::CNT_OUT_W-1:0];
        r.misses_way1 = event_cnt[tsacl_pkg::EV_FILL_W1][tsacl_pkg::CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (mismatches < MAX_REPORTS)
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // monitor: prediction on each input transfer, check on each result transfer
    always @(posedge aclk) begin
        lookup_result_t want;
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            if (aresetn && m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $error("result transfer with no access outstanding");
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("hit", want.hit, m_hit);
                    check_field("way", want.way, m_way);
                    check_field("set_index", want.set_index, m_set_index);
                    check_field("tag_value", want.tag_value, m_tag_value);
                    check_field("line_data", want.line_data, m_line_data);
                    check_field("hits_way0", want.hits_way0, m_hits_way0);
                    check_field("hits_way1", want.hits_way1, m_hits_way1);
                    check_field("misses_way0", want.misses_way0, m_misses_way0);
                    check_field("misses_way1", want.misses_way1, m_misses_way1);
                    results_done++;
                end
            end
            s_taken = aresetn && s_valid && s_ready;
            if (s_taken)
                expected_q.push_back(cache_access('{s_address, s_fill_line}));
        end
    end

    // driver
    always @(negedge aclk) begin
        access_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                nxt = pending_q.pop_front();
                s_valid     <= 1'b1;
                s_address   <= nxt.address;
                s_fill_line <= nxt.fill_line;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side ready, with one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic queue_access(input logic [tsacl_pkg::ADDR_W-1:0] addr,
                                input logic [tsacl_pkg::LINE_W-1:0] fill);
        pending_q.push_back('{addr, fill});
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_done != items_queued)
            @(posedge aclk);
    endtask

    task automatic run_random(input int n, input int src_pct, input int sink_pct);
        logic [tsacl_pkg::SET_OUT_W-1:0] hot_set [4];
        logic [tsacl_pkg::TAG_W-1:0]     hot_tag [3];
        logic [tsacl_pkg::ADDR_W-1:0]    addr;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < n; i++) begin
            if (i % 64 == 0) begin
                foreach (hot_set[j]) hot_set[j] = tsacl_pkg::SET_OUT_W'($urandom);
                foreach (hot_tag[j]) hot_tag[j] = tsacl_pkg::TAG_W'($urandom);
            end
            if ($urandom_range(0, 99) < 75)
                addr = {hot_tag[$urandom_range(0, 2)], hot_set[$urandom_range(0, 3)],
                        2'($urandom)};
            else
                addr = tsacl_pkg::ADDR_W'($urandom);
            queue_access(addr, $urandom);
        end
        wait_drained();
    endtask

    initial begin
        clear_cache_state();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: lru order, eviction, byte offsets, field extremes
        queue_access(16'h0000, 32'hFFFF_FFFF);
        queue_access(16'h0003, 32'h0000_0000);
        queue_access(16'h0100, 32'h1234_5678);
        queue_access(16'h0101, 32'hFFFF_FFFF);
        queue_access(16'h0200, 32'hA5A5_5A5A);
        queue_access(16'h0000, 32'h0F0F_F0F0);
        queue_access(16'h0102, 32'h8000_0001);
        queue_access(16'h0000, 32'h0000_0000);
        queue_access(16'hFFFF, 32'h0000_0000);
        queue_access(16'hFFFC, 32'hFFFF_FFFF);
        queue_access(16'h00FC, 32'h7FFF_FFFE);
        queue_access(16'hFF00, 32'hDEAD_BEEF);
        queue_access(16'hAAAA, 32'h5555_5555);
        queue_access(16'h5555, 32'hAAAA_AAAA);
        queue_access(16'h5554, 32'h0000_0000);
        queue_access(16'hAAA9, 32'h0000_0001);
        wait_drained();

        run_random(300, 0, 0);
        run_random(300, 53, 0);
        run_random(300, 0, 53);
        run_random(300, 7, 7);

        // long result-side hold-off while accesses keep coming
        hold_arm = 1'b1;
        run_random(80, 0, 0);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/tsacl_pkg.sv
hdl/tsacl_ram.sv
hdl/two_way_set_assoc_cache_lookup_core.sv
tb/tb_two_way_set_assoc_cache_lookup_core.sv
